// File: sv/cdp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the threshold screen of the dither packer.
package cdp_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int LANES = 8;

    localparam int K_DIV = 40000;
    localparam int K_HALF = K_DIV / 2;
    localparam int RECIP_SHIFT = 40;
    localparam logic [24:0] RECIP_K = 25'd27487791;
    localparam int B_HALF = 20;
    localparam logic [12:0] RECIP5 = 13'd6554;
    localparam int RECIP5_SHIFT = 15;

    localparam int CONTRAST_MAX = 100;
    localparam int BRIGHT_MAX = 200;
    localparam int BRIGHT_GAIN = 51;

    typedef enum logic [1:0] {
        CFG_CONTRAST   = 2'd0,
        CFG_BRIGHTNESS = 2'd1
    } cdp_cfg_idx_t;

    typedef struct packed {
        logic [7:0] pix0;
        logic [7:0] pix1;
        logic [7:0] pix2;
        logic [7:0] pix3;
        logic [7:0] pix4;
        logic [7:0] pix5;
        logic [7:0] pix6;
        logic [7:0] pix7;
        logic [3:0] valid_count;
        logic       row_end;
        logic       image_start;
    } cdp_in_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_done;
    } cdp_out_t;

    // Lane j of every vector maps to output bit j, so pixel 0 sits in lane 7.
    typedef struct packed {
        logic [7:0][7:0] thr;
        logic [7:0]      mask;
        logic            row_end;
    } cdp_meta_t;

    typedef struct packed {
        logic [7:0][7:0] pix;
        cdp_meta_t       meta;
    } cdp_job_t;

    // One entry per screen row and half; the top byte is the threshold of pixel 0.
    localparam logic [63:0] SCREEN_ROWS [32] = '{
        64'h91B9B1896B434B73, 64'h93BBB38B69414971,
        64'hC1F1E9A13B0B135B, 64'hC3F3EBA339091159,
        64'hC9F9E1A933031B53, 64'hCBFBE3AB31011951,
        64'h99D9D18163232B7B, 64'h9BDBD38361212979,
        64'h6C444C7494BCB48C, 64'h6E464E7696BEB68E,
        64'h3C0C145CC4F4ECA4, 64'h3E0E165EC6F6EEA6,
        64'h34041C54CCFCE4AC, 64'h36061E56CEFEE6AE,
        64'h64242C7C9CDCD484, 64'h66262E7E9EDED686,
        64'h92BAB28A68404870, 64'h90B8B0886A424A72,
        64'hC2F2EAA238081058, 64'hC0F0E8A03A0A125A,
        64'hCAFAE2AA30001850, 64'hC8F8E0A832021A52,
        64'h9ADAD28260202878, 64'h98D8D08062222A7A,
        64'h6F474F7797BFB78F, 64'h6D454D7595BDB58D,
        64'h3F0F175FC7F7EFA7, 64'h3D0D155DC5F5EDA5,
        64'h37071F57CFFEE7AF, 64'h35051D55CDFDE5AD,
        64'h67272F7F9FDFD787, 64'h65252D7D9DDDD585
    };

endpackage

// File: sv/cdp_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixel groups, tracks the screen position and fetches thresholds.
module cdp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cdp_pkg::cdp_in_t   in_word,
    input  logic               q_full,
    output logic               push,
    output cdp_pkg::cdp_job_t  job
);

    logic [3:0] row_reg;
    logic [3:0] row_next;
    logic       half_reg;
    logic       half_next;
    logic       accept;
    logic [3:0] eff_row;
    logic       eff_half;
    logic [3:0] cnt8;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept;

    always_comb
    begin
        eff_row  = in_word.image_start ? 4'd0 : row_reg;
        eff_half = in_word.image_start ? 1'b0 : half_reg;
        cnt8     = (in_word.valid_count > 4'd8) ? 4'd8 : in_word.valid_count;

        job.pix = {in_word.pix0, in_word.pix1, in_word.pix2, in_word.pix3,
                   in_word.pix4, in_word.pix5, in_word.pix6, in_word.pix7};
        job.meta.thr = cdp_pkg::SCREEN_ROWS[{eff_row, eff_half}];
        for (int i = 0; i < cdp_pkg::LANES; i++)
        begin
            job.meta.mask[cdp_pkg::LANES - 1 - i] = (4'(i) < cnt8);
        end
        job.meta.row_end = in_word.row_end;

        row_next  = row_reg;
        half_next = half_reg;
        if (accept)
        begin
            if (in_word.row_end)
            begin
                row_next  = eff_row + 4'd1;
                half_next = 1'b0;
            end
            else if (cnt8 == 4'd8)
            begin
                row_next  = eff_row;
                half_next = ~eff_half;
            end
            else
            begin
                row_next  = eff_row;
                half_next = eff_half;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= 4'd0;
            half_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            half_reg <= half_next;
        end
    end

    a_row_end_clears_half: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_word.row_end |=> half_reg == 1'b0)
        else $error("Half not cleared after row end.");

    a_start_restarts_row: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_word.image_start && !in_word.row_end |=> row_reg == 4'd0)
        else $error("Row not restarted on image start.");

    a_short_group_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_word.row_end && !in_word.image_start && cnt8 != 4'd8
        |=> half_reg == $past(half_reg) && row_reg == $past(row_reg))
        else $error("Short group moved the screen position.");

endmodule

// File: sv/cdp_fifo.sv
`timescale 1ns / 1ps
// Short queue between the front end and the arithmetic back end.
module cdp_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cdp_pkg::cdp_job_t  job_in,
    output logic               full,
    output logic               q_valid,
    output cdp_pkg::cdp_job_t  q_job,
    input  logic               pop
);

    cdp_pkg::cdp_job_t                mem [cdp_pkg::QDEPTH];
    logic [cdp_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [cdp_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [cdp_pkg::QCNT_W-1:0]       count_reg;
    logic [cdp_pkg::QCNT_W-1:0]       count_next;

    assign full    = (count_reg == cdp_pkg::QCNT_W'(cdp_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("Queue popped while empty.");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not grow on push.");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("Queue count did not shrink on pop.");

endmodule

// File: sv/cdp_back.sv
`timescale 1ns / 1ps
// Back end: configuration registers, contrast and brightness pipeline, threshold compare.
module cdp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               q_valid,
    input  cdp_pkg::cdp_job_t  q_job,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output cdp_pkg::cdp_out_t  out_word
);

    localparam int L = cdp_pkg::LANES;

    logic [16:0]        k_reg;
    logic [16:0]        k_next;
    logic signed [14:0] boff_reg;
    logic signed [14:0] boff_next;

    logic signed [7:0]  c_raw;
    logic signed [7:0]  c_sat;
    logic signed [15:0] c_sq;
    logic signed [17:0] c_k;
    logic signed [8:0]  b_raw;
    logic signed [8:0]  b_sat;

    logic               en;

    logic               s1_valid_reg;
    logic [23:0]        s1_mag_reg [L];
    logic [23:0]        s1_mag_next [L];
    logic [L-1:0]       s1_neg_reg;
    logic [L-1:0]       s1_neg_next;
    cdp_pkg::cdp_meta_t s1_meta_reg;

    logic               s2_valid_reg;
    logic [8:0]         s2_q_reg [L];
    logic [8:0]         s2_q_next [L];
    logic [L-1:0]       s2_neg_reg;
    cdp_pkg::cdp_meta_t s2_meta_reg;

    logic               s3_valid_reg;
    logic [11:0]        s3_x_reg [L];
    logic [11:0]        s3_x_next [L];
    logic [L-1:0]       s3_neg_reg;
    logic [L-1:0]       s3_neg_next;
    cdp_pkg::cdp_meta_t s3_meta_reg;

    logic               out_valid_reg;
    cdp_pkg::cdp_out_t  out_word_reg;
    cdp_pkg::cdp_out_t  out_word_next;

    always_comb
    begin
        c_raw = $signed(cfg_data[7:0]);
        if (c_raw < -8'sd100)
        begin
            c_sat = -8'sd100;
        end
        else if (c_raw > 8'(cdp_pkg::CONTRAST_MAX))
        begin
            c_sat = 8'(cdp_pkg::CONTRAST_MAX);
        end
        else
        begin
            c_sat = c_raw;
        end
        c_sq = c_sat * c_sat;
        c_k  = 18'(c_sq) + 18'(c_sat) * 18'sd300 + 18'(cdp_pkg::K_DIV);

        b_raw = $signed(cfg_data);
        if (b_raw < -9'sd200)
        begin
            b_sat = -9'sd200;
        end
        else if (b_raw > 9'(cdp_pkg::BRIGHT_MAX))
        begin
            b_sat = 9'(cdp_pkg::BRIGHT_MAX);
        end
        else
        begin
            b_sat = b_raw;
        end

        k_next    = k_reg;
        boff_next = boff_reg;
        if (cfg_valid)
        begin
            case (cdp_pkg::cdp_cfg_idx_t'(cfg_index))
                cdp_pkg::CFG_CONTRAST:   k_next    = 17'(c_k);
                cdp_pkg::CFG_BRIGHTNESS: boff_next = 15'(b_sat) * 15'(cdp_pkg::BRIGHT_GAIN);
                default:                 k_next    = k_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= 17'(cdp_pkg::K_DIV);
            boff_reg <= '0;
        end
        else
        begin
            k_reg    <= k_next;
            boff_reg <= boff_next;
        end
    end

    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && q_valid;

    // Stage 1: (v - 128) * K. Stage 2: divide by 40000 with rounding. Stage 3: add
    // 128, clamp, apply brightness offset, divide by 8. Stage 4: divide by 5, compare.
    always_comb
    begin
        logic signed [8:0]  d;
        logic signed [26:0] p;
        logic [24:0]        m;
        logic [49:0]        p2;
        logic [9:0]         vc;
        logic [7:0]         vc8;
        logic [15:0]        n2;
        logic [15:0]        a2;
        logic [24:0]        p5;
        logic [9:0]         q2;
        logic [7:0]         vb;
        for (int j = 0; j < L; j++)
        begin
            d  = $signed({~q_job.pix[j][7], q_job.pix[j][6:0]});
            p  = 27'(d) * $signed({10'd0, k_reg});
            s1_mag_next[j] = p[26] ? 24'(-p) : 24'(p);
            s1_neg_next[j] = ~q_job.pix[j][7];

            m  = 25'(s1_mag_reg[j]) + 25'(cdp_pkg::K_HALF);
            p2 = 50'(m) * 50'(cdp_pkg::RECIP_K);
            s2_q_next[j] = p2[cdp_pkg::RECIP_SHIFT +: 9];

            vc = s2_neg_reg[j] ? (10'd128 - 10'(s2_q_reg[j])) : (10'd128 + 10'(s2_q_reg[j]));
            if (vc[9])
            begin
                vc8 = 8'd0;
            end
            else if (vc[8])
            begin
                vc8 = 8'd255;
            end
            else
            begin
                vc8 = vc[7:0];
            end
            n2 = 16'({vc8, 5'd0}) + 16'({vc8, 3'd0}) + {boff_reg[14], boff_reg};
            a2 = n2[15] ? (16'd0 - n2) : n2;
            a2 = a2 + 16'(cdp_pkg::B_HALF);
            s3_x_next[j]   = a2[14:3];
            s3_neg_next[j] = n2[15];

            p5 = 25'(s3_x_reg[j]) * 25'(cdp_pkg::RECIP5);
            q2 = p5[cdp_pkg::RECIP5_SHIFT +: 10];
            if (s3_neg_reg[j])
            begin
                vb = 8'd0;
            end
            else if (q2 > 10'd255)
            begin
                vb = 8'd255;
            end
            else
            begin
                vb = q2[7:0];
            end
            out_word_next.packed_byte[j] = s3_meta_reg.mask[j] && (vb > s3_meta_reg.thr[j]);
        end
        out_word_next.row_done = s3_meta_reg.row_end;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg   <= s1_mag_next;
            s1_neg_reg   <= s1_neg_next;
            s1_meta_reg  <= q_job.meta;
            s2_q_reg     <= s2_q_next;
            s2_neg_reg   <= s1_neg_reg;
            s2_meta_reg  <= s1_meta_reg;
            s3_x_reg     <= s3_x_next;
            s3_neg_reg   <= s3_neg_next;
            s3_meta_reg  <= s2_meta_reg;
            out_word_reg <= out_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_pipe_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> s1_valid_reg == $past(s1_valid_reg) && s3_valid_reg == $past(s3_valid_reg))
        else $error("Pipeline advanced while the output was stalled.");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !q_pop)
        else $error("Queue drained while the output was stalled.");

    a_bits_only_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        en && s3_valid_reg |=> (out_word_reg.packed_byte & ~$past(s3_meta_reg.mask)) == 8'd0)
        else $error("Bit set for a pixel beyond the valid count.");

endmodule

// File: sv/contrast_ordered_dither_packer_core.sv
`timescale 1ns / 1ps
// Top level of the contrast and brightness adjusted ordered-dither packer.
// A word passes the queue, the stage 1 to 3 registers and the output register.
// Throughput: one word per cycle while the queue has room; the four-stage
// arithmetic pipeline takes a group per unstalled cycle, and the four-entry queue
// absorbs output stalls. Reset clears the screen position, the queue and all
// valid flags, and sets contrast and brightness to their neutral values.
module contrast_ordered_dither_packer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cdp_pkg::cdp_in_t   in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output cdp_pkg::cdp_out_t  out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    logic               q_full;
    logic               push;
    cdp_pkg::cdp_job_t  job;
    logic               q_valid;
    cdp_pkg::cdp_job_t  q_job;
    logic               q_pop;

    assign cfg_ready = 1'b1;

    cdp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_full   (q_full),
        .push     (push),
        .job      (job)
    );

    cdp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job),
        .full    (q_full),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (q_pop)
    );

    cdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

// File: test/dither_byte_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every packed dither byte and compares it with the output channel.
module dither_byte_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  cdp_pkg::cdp_in_t   in_word,
    input  logic               out_valid,
    input  logic               out_stall,
    input  cdp_pkg::cdp_out_t  out_word,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output int                 fail_count,
    output int                 pending_count
);

    int contrast_setting;
    int brightness_setting;
    logic [3:0] scr_row;
    logic scr_half;
    cdp_pkg::cdp_out_t expected_bytes [$];
    int errors = 0;
    int pending = 0;

    assign fail_count = errors;
    assign pending_count = pending;

    function automatic logic [63:0] screen_entry(input logic [4:0] sel);
        case (sel)
            5'd0:  return 64'h91B9B1896B434B73;
            5'd1:  return 64'h93BBB38B69414971;
            5'd2:  return 64'hC1F1E9A13B0B135B;
            5'd3:  return 64'hC3F3EBA339091159;
            5'd4:  return 64'hC9F9E1A933031B53;
            5'd5:  return 64'hCBFBE3AB31011951;
            5'd6:  return 64'h99D9D18163232B7B;
            5'd7:  return 64'h9BDBD38361212979;
            5'd8:  return 64'h6C444C7494BCB48C;
            5'd9:  return 64'h6E464E7696BEB68E;
            5'd10: return 64'h3C0C145CC4F4ECA4;
            5'd11: return 64'h3E0E165EC6F6EEA6;
            5'd12: return 64'h34041C54CCFCE4AC;
            5'd13: return 64'h36061E56CEFEE6AE;
            5'd14: return 64'h64242C7C9CDCD484;
            5'd15: return 64'h66262E7E9EDED686;
            5'd16: return 64'h92BAB28A68404870;
            5'd17: return 64'h90B8B0886A424A72;
            5'd18: return 64'hC2F2EAA238081058;
            5'd19: return 64'hC0F0E8A03A0A125A;
            5'd20: return 64'hCAFAE2AA30001850;
            5'd21: return 64'hC8F8E0A832021A52;
            5'd22: return 64'h9ADAD28260202878;
            5'd23: return 64'h98D8D08062222A7A;
            5'd24: return 64'h6F474F7797BFB78F;
            5'd25: return 64'h6D454D7595BDB58D;
            5'd26: return 64'h3F0F175FC7F7EFA7;
            5'd27: return 64'h3D0D155DC5F5EDA5;
            5'd28: return 64'h37071F57CFFEE7AF;
            5'd29: return 64'h35051D55CDFDE5AD;
            5'd30: return 64'h67272F7F9FDFD787;
            default: return 64'h65252D7D9DDDD585;
        endcase
    endfunction

    function automatic int round_div(input int num, input int den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic int clamp_level(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    function automatic int adjust_level(input int v);
        int gain;
        int r;
        r = v;
        if (contrast_setting != 0)
        begin
            gain = contrast_setting * contrast_setting + 300 * contrast_setting + 40000;
            r = clamp_level(128 + round_div((r - 128) * gain, 40000));
        end
        if (brightness_setting != 0)
            r = clamp_level(round_div(40 * r + 51 * brightness_setting, 40));
        return r;
    endfunction

    function automatic cdp_pkg::cdp_out_t predict_byte(input cdp_pkg::cdp_in_t w);
        logic [7:0] px [8];
        logic [63:0] thr;
        int n;
        int lvl;
        cdp_pkg::cdp_out_t r;
        px[0] = w.pix0;
        px[1] = w.pix1;
        px[2] = w.pix2;
        px[3] = w.pix3;
        px[4] = w.pix4;
        px[5] = w.pix5;
        px[6] = w.pix6;
        px[7] = w.pix7;
        n = (w.valid_count > 4'd8) ? 8 : int'(w.valid_count);
        if (w.image_start)
        begin
            scr_row = 4'd0;
            scr_half = 1'b0;
        end
        thr = screen_entry({scr_row, scr_half});
        r.packed_byte = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < n)
            begin
                lvl = adjust_level(int'(px[i]));
                if (lvl > int'(thr[63 - 8 * i -: 8]))
                    r.packed_byte[7 - i] = 1'b1;
            end
        end
        r.row_done = w.row_end;
        if (w.row_end)
        begin
            scr_row = scr_row + 4'd1;
            scr_half = 1'b0;
        end
        else if (n == 8)
        begin
            scr_half = ~scr_half;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cdp_pkg::cdp_out_t want;
        int raw;
        if (!rst_n)
        begin
            contrast_setting = 0;
            brightness_setting = 0;
            scr_row = 4'd0;
            scr_half = 1'b0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cdp_pkg::cdp_cfg_idx_t'(cfg_index))
                    cdp_pkg::CFG_CONTRAST:
                    begin
                        raw = int'($signed(cfg_data[7:0]));
                        contrast_setting = (raw < -100) ? -100 : ((raw > 100) ? 100 : raw);
                    end
                    cdp_pkg::CFG_BRIGHTNESS:
                    begin
                        raw = int'($signed(cfg_data));
                        brightness_setting = (raw < -200) ? -200 : ((raw > 200) ? 200 : raw);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                expected_bytes.push_back(predict_byte(in_word));
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got byte %02h row_done %0b",
                             $time, out_word.packed_byte, out_word.row_done);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_word.packed_byte !== want.packed_byte)
                    begin
                        errors++;
                        $display("%0t: packed_byte mismatch, expected %02h, got %02h",
                                 $time, want.packed_byte, out_word.packed_byte);
                    end
                    if (out_word.row_done !== want.row_done)
                    begin
                        errors++;
                        $display("%0t: row_done mismatch, expected %0b, got %0b",
                                 $time, want.row_done, out_word.row_done);
                    end
                end
            end
        end
        pending = expected_bytes.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the dither packer testbench: clock, reset, stimulus, stalls and verdict.
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 9;
    localparam int WORDS_PER_PHASE = 142;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    cdp_pkg::cdp_in_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    cdp_pkg::cdp_out_t out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = cdp_pkg::CFG_CONTRAST;
    logic [8:0] cfg_data = 9'd0;

    int fail_count;
    int pending_count;
    int send_idle_pct = 32;
    int recv_stall_pct = 71;
    int stuck_cycles = 0;

    contrast_ordered_dither_packer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dither_byte_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(136, 120));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic cdp_pkg::cdp_in_t make_group(input int count, input bit last,
                                                    input bit start);
        cdp_pkg::cdp_in_t w;
        w.pix0 = rand_pixel();
        w.pix1 = rand_pixel();
        w.pix2 = rand_pixel();
        w.pix3 = rand_pixel();
        w.pix4 = rand_pixel();
        w.pix5 = rand_pixel();
        w.pix6 = rand_pixel();
        w.pix7 = rand_pixel();
        w.valid_count = 4'(count);
        w.row_end = last;
        w.image_start = start;
        return w;
    endfunction

    function automatic cdp_pkg::cdp_in_t make_noise();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return cdp_pkg::cdp_in_t'(bits[69:0]);
    endfunction

    task automatic send_word(input cdp_pkg::cdp_in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word = w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cdp_pkg::cdp_cfg_idx_t idx, input logic [8:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic send_rows(input int total);
        int sent;
        int groups;
        bit last;
        sent = 0;
        while (sent < total)
        begin
            groups = $urandom_range(5, 1);
            for (int g = 0; g < groups && sent < total; g++)
            begin
                last = (g == groups - 1);
                if ($urandom_range(9) == 0)
                    send_word(make_noise());
                else
                    send_word(make_group(last ? $urandom_range(8, 1) : 8, last,
                                         (g == 0) && ($urandom_range(39) == 0)));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [8:0] contrast_vals [RANDOM_PHASES];
        logic [8:0] bright_vals [RANDOM_PHASES];
        cdp_pkg::cdp_in_t w;
        contrast_vals = '{9'h080, 9'h07F, 9'($urandom), 9'h000, 9'($urandom),
                          9'h19C, 9'h064, 9'($urandom), 9'($urandom)};
        bright_vals = '{9'h000, 9'h0C8, 9'h100, 9'($urandom), 9'h000,
                        9'h138, 9'h0FF, 9'($urandom), 9'($urandom)};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        w = make_group(8, 1'b0, 1'b1);
        w.pix0 = 8'hFF; w.pix1 = 8'hFF; w.pix2 = 8'hFF; w.pix3 = 8'hFF;
        w.pix4 = 8'hFF; w.pix5 = 8'hFF; w.pix6 = 8'hFF; w.pix7 = 8'hFF;
        send_word(w);
        w = '0;
        w.valid_count = 4'd8;
        send_word(w);
        w = make_group(8, 1'b0, 1'b0);
        w.pix0 = 8'h80; w.pix1 = 8'h7F; w.pix2 = 8'h91; w.pix3 = 8'h92;
        send_word(w);
        send_word(make_group(3, 1'b0, 1'b0));
        send_word(make_group(8, 1'b0, 1'b0));
        w = make_group(0, 1'b0, 1'b0);
        w.pix0 = 8'hFF;
        send_word(w);
        send_word(make_group(15, 1'b0, 1'b0));
        send_word(make_group(9, 1'b0, 1'b0));
        send_word(make_group(8, 1'b1, 1'b0));
        send_word(make_group(5, 1'b1, 1'b0));
        send_word(make_group(1, 1'b1, 1'b0));
        send_word(make_group(8, 1'b1, 1'b1));
        send_word(make_group(8, 1'b0, 1'b0));
        send_word(make_group(0, 1'b1, 1'b0));
        send_word(make_group(12, 1'b1, 1'b1));
        send_word(make_group(8, 1'b0, 1'b1));
        send_word(make_group(7, 1'b1, 1'b0));
        send_word(make_noise());
        send_word(make_noise());
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p / 3)
                0:
                begin
                    send_idle_pct = 32;
                    recv_stall_pct = 71;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_stall_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            write_reg(cdp_pkg::CFG_CONTRAST, contrast_vals[p]);
            write_reg(cdp_pkg::CFG_BRIGHTNESS, bright_vals[p]);
            send_rows(WORDS_PER_PHASE);
            drain();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/cdp_pkg.sv
sv/cdp_front.sv
sv/cdp_fifo.sv
sv/cdp_back.sv
sv/contrast_ordered_dither_packer_core.sv
test/dither_byte_checker.sv
test/testbench.sv
